// ----- rtl/clx_pkg.sv -----
// ----------------------------------------------------------------------------
// Complex ALU package
// Operation codes and the sideband flag group shared by the pipeline modules.
// ----------------------------------------------------------------------------
package clx_pkg;

   localparam logic [3:0] FN_ADD   = 4'd0;
   localparam logic [3:0] FN_SUB   = 4'd1;
   localparam logic [3:0] FN_MUL   = 4'd2;
   localparam logic [3:0] FN_DIV   = 4'd3;
   localparam logic [3:0] FN_CONJ  = 4'd4;
   localparam logic [3:0] FN_NEG   = 4'd5;
   localparam logic [3:0] FN_RECIP = 4'd6;
   localparam logic [3:0] FN_MOD   = 4'd7;
   localparam logic [3:0] FN_EQ    = 4'd8;

   // Flags that ride along the pipeline next to the data.
   typedef struct packed {
      logic [3:0] func;
      logic       eq;
      logic       dz;
      logic       ovf;
   } clx_side_type;

endpackage

// ----- rtl/clx_front.sv -----
// ----------------------------------------------------------------------------
// Complex ALU front end
// Four stages: operand select, products, sums, rounding and divider prep.
// ----------------------------------------------------------------------------
module clx_front #(
   parameter int W = 24,
   parameter int F = 16,
   parameter int SW = 50
) (
   input  logic                       clock,
   input  logic                       en,
   input  logic [3:0]                 req_func,
   input  logic signed [W-1:0]        req_x_re,
   input  logic signed [W-1:0]        req_x_im,
   input  logic signed [W-1:0]        req_y_re,
   input  logic signed [W-1:0]        req_y_im,
   output clx_pkg::clx_side_type      side,
   output logic signed [W-1:0]        res_re,
   output logic signed [W-1:0]        res_im,
   output logic                       nre_neg,
   output logic [SW-1:0]              nre_mag,
   output logic                       nim_neg,
   output logic [SW-1:0]              nim_mag,
   output logic [2*W-1:0]             den,
   output logic [2*W-1:0]             sq
);
   import clx_pkg::*;

   localparam int AW = SW - W - 1;
   localparam int PW = AW + W;

   function automatic logic [W:0] sat_w1(input logic signed [W:0] v);
      logic o;
      o = v[W] != v[W-1];
      return {o, o ? {v[W], {(W-1){~v[W]}}} : v[W-1:0]};
   endfunction

   function automatic logic [W:0] rnd_sat(input logic signed [SW-1:0] v);
      logic          neg;
      logic [SW-1:0] mag;
      logic [SW:0]   rm;
      logic [SW:0]   lim;
      logic          o;
      logic [W-1:0]  val;
      neg = v[SW-1];
      mag = neg ? (~v + {{(SW-1){1'b0}}, 1'b1}) : v;
      rm  = ({1'b0, mag} + ({{SW{1'b0}}, 1'b1} << (F-1))) >> F;
      lim = {{SW{1'b0}}, 1'b1} << (W-1);
      if (neg) begin
         o   = rm > lim;
         val = o ? lim[W-1:0] : (~rm[W-1:0] + 1'b1);
      end else begin
         o   = rm > (lim - 1'b1);
         val = o ? (lim[W-1:0] - 1'b1) : rm[W-1:0];
      end
      return {o, val};
   endfunction

   // Stage 1: operand selection and the single-step operations.
   logic signed [AW-1:0] one_c, a_re, a_im;
   logic signed [W-1:0]  b_re, b_im, sre, sim;
   logic                 sovf, seq, o1, o2;

   logic [3:0]           func1_ff;
   logic signed [AW-1:0] a_re1_ff, a_im1_ff;
   logic signed [W-1:0]  b_re1_ff, b_im1_ff, x_re1_ff, x_im1_ff, sre1_ff, sim1_ff;
   logic                 sovf1_ff, eq1_ff;

   assign one_c = {{(AW-1){1'b0}}, 1'b1} << F;

   always_comb begin
      a_re = AW'(req_x_re);
      a_im = AW'(req_x_im);
      b_re = req_y_re;
      b_im = req_y_im;
      sre  = '0;
      sim  = '0;
      o1   = 1'b0;
      o2   = 1'b0;
      seq  = 1'b0;
      case (req_func) inside
         FN_ADD: begin
            {o1, sre} = sat_w1((W+1)'(req_x_re) + (W+1)'(req_y_re));
            {o2, sim} = sat_w1((W+1)'(req_x_im) + (W+1)'(req_y_im));
         end
         FN_SUB: begin
            {o1, sre} = sat_w1((W+1)'(req_x_re) - (W+1)'(req_y_re));
            {o2, sim} = sat_w1((W+1)'(req_x_im) - (W+1)'(req_y_im));
         end
         FN_CONJ: begin
            sre       = req_x_re;
            {o2, sim} = sat_w1(-((W+1)'(req_x_im)));
         end
         FN_NEG: begin
            {o1, sre} = sat_w1(-((W+1)'(req_x_re)));
            {o2, sim} = sat_w1(-((W+1)'(req_x_im)));
         end
         FN_RECIP: begin
            a_re = one_c;
            a_im = '0;
            b_re = req_x_re;
            b_im = req_x_im;
         end
         FN_EQ: seq = (req_x_re == req_y_re) && (req_x_im == req_y_im);
         default: ;
      endcase
      sovf = o1 | o2;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         func1_ff <= req_func;
         a_re1_ff <= a_re;
         a_im1_ff <= a_im;
         b_re1_ff <= b_re;
         b_im1_ff <= b_im;
         x_re1_ff <= req_x_re;
         x_im1_ff <= req_x_im;
         sre1_ff  <= sre;
         sim1_ff  <= sim;
         sovf1_ff <= sovf;
         eq1_ff   <= seq;
      end
   end

   // Stage 2: the eight products.
   logic signed [PW-1:0]  p_rr2_ff, p_ii2_ff, p_ri2_ff, p_ir2_ff;
   logic signed [2*W-1:0] bsq_re2_ff, bsq_im2_ff, xsq_re2_ff, xsq_im2_ff;
   logic [3:0]            func2_ff;
   logic signed [W-1:0]   sre2_ff, sim2_ff;
   logic                  sovf2_ff, eq2_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         p_rr2_ff   <= a_re1_ff * PW'(b_re1_ff);
         p_ii2_ff   <= a_im1_ff * PW'(b_im1_ff);
         p_ri2_ff   <= a_re1_ff * PW'(b_im1_ff);
         p_ir2_ff   <= a_im1_ff * PW'(b_re1_ff);
         bsq_re2_ff <= (2*W)'(b_re1_ff) * (2*W)'(b_re1_ff);
         bsq_im2_ff <= (2*W)'(b_im1_ff) * (2*W)'(b_im1_ff);
         xsq_re2_ff <= (2*W)'(x_re1_ff) * (2*W)'(x_re1_ff);
         xsq_im2_ff <= (2*W)'(x_im1_ff) * (2*W)'(x_im1_ff);
         func2_ff   <= func1_ff;
         sre2_ff    <= sre1_ff;
         sim2_ff    <= sim1_ff;
         sovf2_ff   <= sovf1_ff;
         eq2_ff     <= eq1_ff;
      end
   end

   // Stage 3: sums of products.
   logic signed [SW-1:0] mre3_ff, mim3_ff, nre3_ff, nim3_ff;
   logic [2*W-1:0]       den3_ff, sq3_ff;
   logic [3:0]           func3_ff;
   logic signed [W-1:0]  sre3_ff, sim3_ff;
   logic                 sovf3_ff, eq3_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         mre3_ff  <= SW'(p_rr2_ff) - SW'(p_ii2_ff);
         mim3_ff  <= SW'(p_ri2_ff) + SW'(p_ir2_ff);
         nre3_ff  <= SW'(p_rr2_ff) + SW'(p_ii2_ff);
         nim3_ff  <= SW'(p_ir2_ff) - SW'(p_ri2_ff);
         den3_ff  <= $unsigned(bsq_re2_ff) + $unsigned(bsq_im2_ff);
         sq3_ff   <= $unsigned(xsq_re2_ff) + $unsigned(xsq_im2_ff);
         func3_ff <= func2_ff;
         sre3_ff  <= sre2_ff;
         sim3_ff  <= sim2_ff;
         sovf3_ff <= sovf2_ff;
         eq3_ff   <= eq2_ff;
      end
   end

   // Stage 4: product rounding, operation merge and divider operands.
   logic [W:0]          mr_re, mr_im;
   logic                is_div;
   clx_side_type        side_in, side_ff;
   logic signed [W-1:0] re_in, im_in, re_ff, im_ff;
   logic                nre_neg_ff, nim_neg_ff;
   logic [SW-1:0]       nre_mag_ff, nim_mag_ff;
   logic [2*W-1:0]      den_ff, sq_ff;

   always_comb begin
      mr_re        = rnd_sat(mre3_ff);
      mr_im        = rnd_sat(mim3_ff);
      is_div       = (func3_ff == FN_DIV) || (func3_ff == FN_RECIP);
      side_in.func = func3_ff;
      side_in.eq   = eq3_ff;
      side_in.dz   = is_div && (den3_ff == '0);
      if (func3_ff == FN_MUL) begin
         re_in       = mr_re[W-1:0];
         im_in       = mr_im[W-1:0];
         side_in.ovf = mr_re[W] | mr_im[W];
      end else begin
         re_in       = sre3_ff;
         im_in       = sim3_ff;
         side_in.ovf = sovf3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff    <= side_in;
         re_ff      <= re_in;
         im_ff      <= im_in;
         nre_neg_ff <= nre3_ff[SW-1];
         nre_mag_ff <= nre3_ff[SW-1] ? $unsigned(-nre3_ff) : $unsigned(nre3_ff);
         nim_neg_ff <= nim3_ff[SW-1];
         nim_mag_ff <= nim3_ff[SW-1] ? $unsigned(-nim3_ff) : $unsigned(nim3_ff);
         den_ff     <= den3_ff;
         sq_ff      <= sq3_ff;
      end
   end

   assign side    = side_ff;
   assign res_re  = re_ff;
   assign res_im  = im_ff;
   assign nre_neg = nre_neg_ff;
   assign nre_mag = nre_mag_ff;
   assign nim_neg = nim_neg_ff;
   assign nim_mag = nim_mag_ff;
   assign den     = den_ff;
   assign sq      = sq_ff;

endmodule

// ----- rtl/clx_div.sv -----
// ----------------------------------------------------------------------------
// Complex ALU divider lane
// Pipelined restoring divider, one quotient bit per stage, rounded and saturated.
// ----------------------------------------------------------------------------
module clx_div #(
   parameter int W = 24,
   parameter int F = 16,
   parameter int NW = 50
) (
   input  logic                clock,
   input  logic                en,
   input  logic                neg,
   input  logic [NW-1:0]       mag,
   input  logic [2*W-1:0]      den,
   output logic signed [W-1:0] quo,
   output logic                ovf
);
   localparam int CW = ((NW + F > 3*W) ? NW + F : 3*W) + 1;

   logic [CW-1:0]  r_ff [0:W];
   logic [2*W-1:0] d_ff [0:W];
   logic [W-1:0]   q_ff [0:W];
   logic           neg_ff [0:W];
   logic           big_ff [0:W];

   logic [CW-1:0] num0, dsh0;

   // Entry stage: scale the numerator and flag quotients that need more than W bits.
   assign num0 = CW'(mag) << F;
   assign dsh0 = CW'(den) << W;

   always_ff @(posedge clock) begin
      if (en) begin
         r_ff[0]   <= num0;
         d_ff[0]   <= den;
         q_ff[0]   <= '0;
         neg_ff[0] <= neg;
         big_ff[0] <= num0 >= dsh0;
      end
   end

   for (genvar j = 0; j < W; j++) begin : g_bit
      logic [CW-1:0] dk;
      logic          ge;
      assign dk = CW'(d_ff[j]) << (W - 1 - j);
      assign ge = r_ff[j] >= dk;
      always_ff @(posedge clock) begin
         if (en) begin
            r_ff[j+1]   <= ge ? r_ff[j] - dk : r_ff[j];
            q_ff[j+1]   <= {q_ff[j][W-2:0], ge};
            d_ff[j+1]   <= d_ff[j];
            neg_ff[j+1] <= neg_ff[j];
            big_ff[j+1] <= big_ff[j];
         end
      end
   end

   // Round to nearest on the remainder, then saturate.
   logic [W:0]     qr, lim;
   logic           half, o;
   logic [W-1:0]   val;
   logic [W-1:0]   quo_ff;
   logic           ovf_ff;

   always_comb begin
      half = (r_ff[W] << 1) >= CW'(d_ff[W]);
      qr   = {1'b0, q_ff[W]} + {{W{1'b0}}, half};
      lim  = {{W{1'b0}}, 1'b1} << (W-1);
      if (neg_ff[W]) begin
         o   = big_ff[W] || (qr > lim);
         val = o ? lim[W-1:0] : (~qr[W-1:0] + 1'b1);
      end else begin
         o   = big_ff[W] || (qr > (lim - 1'b1));
         val = o ? (lim[W-1:0] - 1'b1) : qr[W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         quo_ff <= val;
         ovf_ff <= o;
      end
   end

   assign quo = quo_ff;
   assign ovf = ovf_ff;

endmodule

// ----- rtl/clx_sqrt.sv -----
// ----------------------------------------------------------------------------
// Complex ALU square root lane
// Pipelined bit-by-bit integer square root with round to nearest.
// ----------------------------------------------------------------------------
module clx_sqrt #(
   parameter int W = 24
) (
   input  logic           clock,
   input  logic           en,
   input  logic [2*W-1:0] sq,
   output logic [W-1:0]   mag,
   output logic           ovf
);
   localparam int TW = 2*W + 2;

   logic [TW-1:0] r_ff [0:W-1];
   logic [W-1:0]  m_ff [0:W-1];

   // Remainder holds sq minus the square of the partial root.
   for (genvar j = 0; j < W; j++) begin : g_bit
      logic [TW-1:0] r_prev, t;
      logic [W-1:0]  m_prev;
      logic          ge;
      if (j == 0) begin : g_first
         assign r_prev = TW'(sq);
         assign m_prev = '0;
      end else begin : g_next
         assign r_prev = r_ff[j-1];
         assign m_prev = m_ff[j-1];
      end
      assign t  = (TW'(m_prev) << (W - j)) + (TW'(1'b1) << (2*(W - 1 - j)));
      assign ge = r_prev >= t;
      always_ff @(posedge clock) begin
         if (en) begin
            r_ff[j] <= ge ? r_prev - t : r_prev;
            m_ff[j] <= m_prev | (W'(ge) << (W - 1 - j));
         end
      end
   end

   logic [W:0]   mr_ff;
   logic [W-1:0] mag_ff;
   logic         ovf_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         mr_ff  <= {1'b0, m_ff[W-1]} + {{W{1'b0}}, (r_ff[W-1] > TW'(m_ff[W-1]))};
         mag_ff <= mr_ff[W] ? '1 : mr_ff[W-1:0];
         ovf_ff <= mr_ff[W];
      end
   end

   assign mag = mag_ff;
   assign ovf = ovf_ff;

endmodule

// ----- rtl/complex_number_alu.sv -----
// ----------------------------------------------------------------------------
// Complex number ALU
// Pipelined add, sub, mul, div, conjugate, negate, reciprocal, modulus, equal.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+------------------------------------
//   req     | in        | req_valid / req_ready | func, x_re, x_im, y_re, y_im
//   rsp     | out       | rsp_valid / rsp_ready | res_re, res_im, magnitude, flags
//
// A word can enter every cycle while the output word is not held; it passes
// four front-end stages, DATA_WIDTH + 2 stages for the dividers and the square
// root (one quotient or root bit per stage) and one output register.
// Reset clears only the valid bits; data registers are not reset.
// When the output word is held by rsp_ready low, the whole pipeline freezes
// in place, so no word is lost or duplicated.
//
module complex_number_alu #(
   parameter int FRAC_BITS  = 16,
   parameter int DATA_WIDTH = 24
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [3:0]                   req_func,
   input  logic signed [DATA_WIDTH-1:0] req_x_re,
   input  logic signed [DATA_WIDTH-1:0] req_x_im,
   input  logic signed [DATA_WIDTH-1:0] req_y_re,
   input  logic signed [DATA_WIDTH-1:0] req_y_im,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [DATA_WIDTH-1:0] rsp_res_re,
   output logic signed [DATA_WIDTH-1:0] rsp_res_im,
   output logic [DATA_WIDTH-1:0]        rsp_magnitude,
   output logic                         rsp_is_equal,
   output logic                         rsp_div_zero,
   output logic                         rsp_overflow
);
   import clx_pkg::*;

   localparam int W   = DATA_WIDTH;
   // The first operand must hold 1.0 for the reciprocal.
   localparam int AW  = (FRAC_BITS + 2 > W) ? FRAC_BITS + 2 : W;
   localparam int SW  = AW + W + 1;
   localparam int LAT = W + 7;

   logic [LAT-1:0] vld_ff;
   logic           en;

   // Single advance enable: everything moves unless the output word is held.
   assign en        = !vld_ff[LAT-1] || rsp_ready;
   assign req_ready = en;
   assign rsp_valid = vld_ff[LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[LAT-2:0], req_valid};
      end
   end

   clx_side_type        f_side;
   logic signed [W-1:0] f_re, f_im;
   logic                f_nre_neg, f_nim_neg;
   logic [SW-1:0]       f_nre_mag, f_nim_mag;
   logic [2*W-1:0]      f_den, f_sq;

   clx_front #(.W(W), .F(FRAC_BITS), .SW(SW)) u_front (
      .clock    (clock),
      .en       (en),
      .req_func (req_func),
      .req_x_re (req_x_re),
      .req_x_im (req_x_im),
      .req_y_re (req_y_re),
      .req_y_im (req_y_im),
      .side     (f_side),
      .res_re   (f_re),
      .res_im   (f_im),
      .nre_neg  (f_nre_neg),
      .nre_mag  (f_nre_mag),
      .nim_neg  (f_nim_neg),
      .nim_mag  (f_nim_mag),
      .den      (f_den),
      .sq       (f_sq)
   );

   logic signed [W-1:0] d_re, d_im;
   logic                d_re_ovf, d_im_ovf;
   logic [W-1:0]        s_mag;
   logic                s_ovf;

   clx_div #(.W(W), .F(FRAC_BITS), .NW(SW)) u_div_re (
      .clock (clock),
      .en    (en),
      .neg   (f_nre_neg),
      .mag   (f_nre_mag),
      .den   (f_den),
      .quo   (d_re),
      .ovf   (d_re_ovf)
   );

   clx_div #(.W(W), .F(FRAC_BITS), .NW(SW)) u_div_im (
      .clock (clock),
      .en    (en),
      .neg   (f_nim_neg),
      .mag   (f_nim_mag),
      .den   (f_den),
      .quo   (d_im),
      .ovf   (d_im_ovf)
   );

   clx_sqrt #(.W(W)) u_sqrt (
      .clock (clock),
      .en    (en),
      .sq    (f_sq),
      .mag   (s_mag),
      .ovf   (s_ovf)
   );

   // Delay line that keeps the front-end results aligned with the lanes.
   clx_side_type        side_d_ff [0:W+1];
   logic signed [W-1:0] re_d_ff   [0:W+1];
   logic signed [W-1:0] im_d_ff   [0:W+1];

   always_ff @(posedge clock) begin
      if (en) begin
         side_d_ff[0] <= f_side;
         re_d_ff[0]   <= f_re;
         im_d_ff[0]   <= f_im;
         for (int i = 1; i < W + 2; i++) begin
            side_d_ff[i] <= side_d_ff[i-1];
            re_d_ff[i]   <= re_d_ff[i-1];
            im_d_ff[i]   <= im_d_ff[i-1];
         end
      end
   end

   // Final merge. A zero divisor forces a zero result and clears overflow,
   // including any overflow of the magnitude.
   clx_side_type        sd;
   logic                use_div;
   logic signed [W-1:0] re_in, im_in;
   logic                ovf_in;
   logic signed [W-1:0] re_ff, im_ff;
   logic [W-1:0]        mag_ff;
   logic                eq_ff, dz_ff, ovf_ff;

   always_comb begin
      sd      = side_d_ff[W+1];
      use_div = ((sd.func == FN_DIV) || (sd.func == FN_RECIP)) && !sd.dz;
      re_in   = use_div ? d_re : re_d_ff[W+1];
      im_in   = use_div ? d_im : im_d_ff[W+1];
      ovf_in  = !sd.dz && (sd.ovf || s_ovf || (use_div && (d_re_ovf || d_im_ovf)));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         re_ff  <= re_in;
         im_ff  <= im_in;
         mag_ff <= s_mag;
         eq_ff  <= sd.eq;
         dz_ff  <= sd.dz;
         ovf_ff <= ovf_in;
      end
   end

   assign rsp_res_re    = re_ff;
   assign rsp_res_im    = im_ff;
   assign rsp_magnitude = mag_ff;
   assign rsp_is_equal  = eq_ff;
   assign rsp_div_zero  = dz_ff;
   assign rsp_overflow  = ovf_ff;

`ifndef SYNTHESIS
   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_div_zero |-> rsp_res_re == '0 && rsp_res_im == '0 && !rsp_overflow)
      else $error("division by zero word carries a nonzero result");

   a_eq_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_equal |-> rsp_res_re == '0 && rsp_res_im == '0 && !rsp_div_zero)
      else $error("equal word carries a result or a zero-divisor flag");

   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled while the output stage is empty");

   a_advance: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !req_valid |=> !vld_ff[0])
      else $error("bubble did not enter the pipeline");
`endif

endmodule

// ----- tb/complex_number_alu_test.sv -----
// ----------------------------------------------------------------------------
// Complex number ALU testbench
// Streams directed and random operand words through the ALU with random idle
// gaps on both channels, predicts every result word with an exact wide
// arithmetic model and compares each returned word field by field.
// ----------------------------------------------------------------------------
module complex_number_alu_test;
   import clx_pkg::*;

   localparam int FB = 16;
   localparam int DW = 24;
   // Quiet cycles after which the run is declared hung.
   localparam int HANG_LIMIT = 4000;

   typedef logic signed [127:0] wide_type;

   typedef struct {
      logic [3:0]          func;
      logic signed [DW-1:0] x_re, x_im, y_re, y_im;
      bit                  drain;   // hold this word back until all results are in
   } op_word_type;

   typedef struct {
      logic signed [DW-1:0] re, im;
      logic [DW-1:0]        mag;
      logic                 eq, dz, ovf;
   } res_word_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [3:0]           req_func = '0;
   logic signed [DW-1:0] req_x_re = '0, req_x_im = '0, req_y_re = '0, req_y_im = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic signed [DW-1:0] rsp_res_re, rsp_res_im;
   logic [DW-1:0]        rsp_magnitude;
   logic                 rsp_is_equal, rsp_div_zero, rsp_overflow;

   op_word_type  pending_ops[$];
   res_word_type expected_results[$];
   int           error_count = 0;
   int           quiet_cycles = 0;

   complex_number_alu #(.FRAC_BITS(FB), .DATA_WIDTH(DW)) dut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Prediction. All intermediates are held in 128 bits, far wider than any
   // product or shifted numerator can grow, so the math below is exact.
   // ---------------------------------------------------------------------

   // Clamp to the signed data range and flag the clamp.
   function automatic logic signed [DW-1:0] clamp(input wide_type v, inout logic ovf);
      wide_type hi = (wide_type'(1) <<< (DW - 1)) - 1;
      wide_type lo = -(wide_type'(1) <<< (DW - 1));
      if (v > hi) begin
         ovf = 1'b1;
         return hi[DW-1:0];
      end
      if (v < lo) begin
         ovf = 1'b1;
         return lo[DW-1:0];
      end
      return v[DW-1:0];
   endfunction

   // Drop the fraction bits of a product, rounding half away from zero.
   function automatic wide_type round_frac(input wide_type v);
      wide_type m = (v < 0) ? -v : v;
      m = (m + (wide_type'(1) <<< (FB - 1))) >>> FB;
      return (v < 0) ? -m : m;
   endfunction

   // Quotient of n scaled by the fraction, rounded half away from zero.
   function automatic wide_type scaled_quotient(input wide_type n, input wide_type den);
      wide_type m = (n < 0) ? -n : n;
      wide_type q, r;
      m = m <<< FB;
      q = m / den;
      r = m % den;
      if (2 * r >= den) q = q + 1;
      return (n < 0) ? -q : q;
   endfunction

   // Complex quotient a / b; dz set when b is zero.
   function automatic void complex_quotient(input wide_type ar, ai, br, bi,
                                            inout res_word_type r);
      wide_type den = br * br + bi * bi;
      if (den == 0) begin
         r.dz = 1'b1;
         return;
      end
      r.re = clamp(scaled_quotient(ar * br + ai * bi, den), r.ovf);
      r.im = clamp(scaled_quotient(ai * br - ar * bi, den), r.ovf);
   endfunction

   // Square root of re^2 + im^2, rounded to nearest.
   function automatic wide_type modulus(input wide_type a, input wide_type b);
      wide_type s = a * a + b * b;
      wide_type m = 0;
      wide_type c;
      for (int k = 48; k >= 0; k--) begin
         c = m | (wide_type'(1) <<< k);
         if (c * c <= s) m = c;
      end
      if (s - m * m > m) m = m + 1;
      return m;
   endfunction

   function automatic res_word_type alu_result(input op_word_type w);
      res_word_type r;
      wide_type xr = w.x_re, xi = w.x_im, yr = w.y_re, yi = w.y_im;
      wide_type mag;
      r = '{re: '0, im: '0, mag: '0, eq: 1'b0, dz: 1'b0, ovf: 1'b0};
      mag = modulus(xr, xi);
      if (mag > (wide_type'(1) <<< DW) - 1) begin
         mag = (wide_type'(1) <<< DW) - 1;
         r.ovf = 1'b1;
      end
      r.mag = mag[DW-1:0];
      case (w.func)
         FN_ADD: begin
            r.re = clamp(xr + yr, r.ovf);
            r.im = clamp(xi + yi, r.ovf);
         end
         FN_SUB: begin
            r.re = clamp(xr - yr, r.ovf);
            r.im = clamp(xi - yi, r.ovf);
         end
         FN_MUL: begin
            r.re = clamp(round_frac(xr * yr - xi * yi), r.ovf);
            r.im = clamp(round_frac(xr * yi + xi * yr), r.ovf);
         end
         FN_DIV:   complex_quotient(xr, xi, yr, yi, r);
         FN_CONJ: begin
            r.re = clamp(xr, r.ovf);
            r.im = clamp(-xi, r.ovf);
         end
         FN_NEG: begin
            r.re = clamp(-xr, r.ovf);
            r.im = clamp(-xi, r.ovf);
         end
         FN_RECIP: complex_quotient(wide_type'(1) <<< FB, 0, xr, xi, r);
         FN_EQ:    r.eq = (xr == yr) && (xi == yi);
         default: ;
      endcase
      // A zero divisor forces a clean zero result with no overflow.
      if (r.dz) begin
         r.re = '0;
         r.im = '0;
         r.ovf = 1'b0;
      end
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   // Operand value biased toward the corners: extremes, zero, small values.
   function automatic logic signed [DW-1:0] pick_operand();
      case ($urandom_range(0, 9))
         0: return {1'b0, {(DW-1){1'b1}}};
         1: return {1'b1, {(DW-1){1'b0}}};
         2: return '0;
         3, 4: return DW'($signed($urandom_range(0, 1 << (FB + 3))) - (1 << (FB + 2)));
         default: return DW'($urandom);
      endcase
   endfunction

   // Idle length: mostly none or short, now and then a long pause.
   function automatic int pick_gap();
      int p = $urandom_range(0, 99);
      if (p < 60) return 0;
      if (p < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic op_word_type make_op(input logic [3:0] f,
                                           input logic signed [DW-1:0] a, b, c, d);
      op_word_type w;
      w.func = f; w.x_re = a; w.x_im = b; w.y_re = c; w.y_im = d; w.drain = 0;
      return w;
   endfunction

   task automatic report(input string field, input logic [DW-1:0] got, want);
      $display("mismatch on %s: got %h, expected %h", field, got, want);
      error_count++;
   endtask

   // ---------------------------------------------------------------------
   // Driver: presents queued words, inserting random gaps between them.
   // Idling is turned off for whole stretches so back to back traffic
   // is exercised too. A drain word waits until the pipeline is empty.
   // ---------------------------------------------------------------------
   int send_gap = 0;
   bit send_idle_on = 1;

   always @(posedge clock) begin
      op_word_type w;
      bit          next_valid;
      if (!reset) begin
         next_valid = req_valid;
         if (req_valid && req_ready) begin
            w = make_op(req_func, req_x_re, req_x_im, req_y_re, req_y_im);
            expected_results.push_back(alu_result(w));
            next_valid = 1'b0;
            send_gap = send_idle_on ? pick_gap() : 0;
            if ($urandom_range(0, 63) == 0) send_idle_on = !send_idle_on;
         end
         if (!next_valid) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (pending_ops.size() > 0 &&
                         (!pending_ops[0].drain || expected_results.size() == 0)) begin
               w = pending_ops.pop_front();
               req_func <= w.func;
               req_x_re <= w.x_re;
               req_x_im <= w.x_im;
               req_y_re <= w.y_re;
               req_y_im <= w.y_im;
               next_valid = 1'b1;
            end
         end
         req_valid <= next_valid;
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: random backpressure, and each accepted result word is
   // checked against the oldest prediction.
   // ---------------------------------------------------------------------
   int  recv_stall = 0;
   bit  recv_idle_on = 1;

   always @(posedge clock) begin
      res_word_type e;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               $display("result word arrived with nothing expected");
               error_count++;
            end else begin
               e = expected_results.pop_front();
               if (rsp_res_re !== e.re)     report("res_re", rsp_res_re, e.re);
               if (rsp_res_im !== e.im)     report("res_im", rsp_res_im, e.im);
               if (rsp_magnitude !== e.mag) report("magnitude", rsp_magnitude, e.mag);
               if (rsp_is_equal !== e.eq)
                  report("is_equal", DW'(rsp_is_equal), DW'(e.eq));
               if (rsp_div_zero !== e.dz)
                  report("div_zero", DW'(rsp_div_zero), DW'(e.dz));
               if (rsp_overflow !== e.ovf)
                  report("overflow", DW'(rsp_overflow), DW'(e.ovf));
            end
         end
         if (recv_stall > 0) begin
            recv_stall--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            recv_stall = recv_idle_on ? pick_gap() : 0;
            if ($urandom_range(0, 63) == 0) recv_idle_on = !recv_idle_on;
         end
      end
   end

   // Watchdog: any cycle without a handshake on either side counts as quiet.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= HANG_LIMIT) begin
            $display("timeout: no traffic for %0d cycles", HANG_LIMIT);
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------
   initial begin
      logic signed [DW-1:0] smax, smin, one;
      op_word_type w;
      smax = {1'b0, {(DW-1){1'b1}}};
      smin = {1'b1, {(DW-1){1'b0}}};
      one  = DW'(1 << FB);

      // Directed corners: saturation of every arithmetic path, zero divisors,
      // negation of the most negative value, equality and unused codes.
      pending_ops.push_back(make_op(FN_ADD, smax, smax, smax, one));
      pending_ops.push_back(make_op(FN_ADD, smin, smin, smin, -one));
      pending_ops.push_back(make_op(FN_SUB, smin, smax, smax, smin));
      pending_ops.push_back(make_op(FN_SUB, one, -one, one, one));
      pending_ops.push_back(make_op(FN_MUL, smin, smin, smin, smin));
      pending_ops.push_back(make_op(FN_MUL, smax, smax, smin, smax));
      pending_ops.push_back(make_op(FN_MUL, 24'sd1, 24'sd0, 24'sd32768, 24'sd0));
      pending_ops.push_back(make_op(FN_MUL, -24'sd1, 24'sd0, 24'sd32768, 24'sd0));
      pending_ops.push_back(make_op(FN_DIV, one, one, 24'sd0, 24'sd0));
      pending_ops.push_back(make_op(FN_DIV, smax, smin, 24'sd1, 24'sd0));
      pending_ops.push_back(make_op(FN_DIV, one, 24'sd0, 24'sd0, DW'(3 * one)));
      pending_ops.push_back(make_op(FN_CONJ, smin, smin, 24'sd0, 24'sd0));
      pending_ops.push_back(make_op(FN_CONJ, smax, smax, 24'sd0, 24'sd0));
      pending_ops.push_back(make_op(FN_NEG, smin, smax, 24'sd0, 24'sd0));
      pending_ops.push_back(make_op(FN_RECIP, 24'sd0, 24'sd0, one, one));
      pending_ops.push_back(make_op(FN_RECIP, 24'sd1, 24'sd0, 24'sd0, 24'sd0));
      pending_ops.push_back(make_op(FN_RECIP, smin, smax, 24'sd0, 24'sd0));
      pending_ops.push_back(make_op(FN_MOD, smin, smin, 24'sd0, 24'sd0));
      pending_ops.push_back(make_op(FN_MOD, smax, 24'sd0, smax, smax));
      pending_ops.push_back(make_op(FN_EQ, smin, smax, smin, smax));
      pending_ops.push_back(make_op(FN_EQ, smin, smax, smin, DW'(smax - 1)));
      pending_ops.push_back(make_op(4'd9, smax, smax, smax, smax));
      pending_ops.push_back(make_op(4'd15, smin, smin, smin, smin));

      // Random words; most use valid codes, a few the unused ones. Every so
      // often the second operand copies the first so equality really hits.
      for (int i = 0; i < 1000; i++) begin
         w.func = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(9, 15))
                                              : 4'($urandom_range(0, 8));
         w.x_re = pick_operand();
         w.x_im = pick_operand();
         w.y_re = pick_operand();
         w.y_im = pick_operand();
         if ($urandom_range(0, 7) == 0) begin
            w.y_re = w.x_re;
            w.y_im = w.x_im;
         end
         w.drain = (i % 250 == 125);
         pending_ops.push_back(w);
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while (pending_ops.size() > 0 || req_valid || expected_results.size() > 0)
         @(posedge clock);
      // Let anything unexpected still in the pipeline surface.
      repeat (2 * (DW + 7)) @(posedge clock);

      if (error_count == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

endmodule
